[hdl/i2scdc_pkg.sv]
// i2scdc_pkg: shared constants and sideband types for the i2s clock divider calculator
// no dependencies; used by i2scdc_div_pipe and i2s_clock_divider_calc_top
package i2scdc_pkg;

    localparam int unsigned DIV_W   = 32;
    localparam int unsigned TAG_W   = 48;
    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned M_TDATA_W = 56;

    localparam logic [8:0] DIV_MIN      = 9'd4;
    localparam logic [8:0] DIV_MAX      = 9'h1ff;
    localparam logic [3:0] SHIFT_MCK    = 4'd7;
    localparam logic [3:0] SHIFT_BASE   = 4'd4;
    localparam logic [3:0] FMT_FIRST_PCM = 4'd3;

    // sideband riding along the first divider
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  fmt;
        logic        pol;
        logic        mck;
        logic        chlen;
        logic [1:0]  datlen;
        logic [3:0]  shift;
        logic [31:0] src;
        logic        rate_zero;
    } tag1_t;

    // sideband riding along the second divider
    typedef struct packed {
        logic [24:0] pad;
        logic [11:0] cfg;
        logic        mck;
        logic        rate_zero;
        logic [8:0]  div;
    } tag2_t;

endpackage

[hdl/i2scdc_div_pipe.sv]
// i2scdc_div_pipe: 32-bit restoring divider, one quotient bit per register stage
// depends on i2scdc_pkg; divide by zero yields an all-ones quotient
module i2scdc_div_pipe (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [i2scdc_pkg::DIV_W-1:0] dividend,
    input  logic [i2scdc_pkg::DIV_W-1:0] divisor,
    input  logic [i2scdc_pkg::TAG_W-1:0] in_tag,
    output logic                         out_valid,
    output logic [i2scdc_pkg::DIV_W-1:0] quotient,
    output logic [i2scdc_pkg::TAG_W-1:0] out_tag
);

    localparam int unsigned N = i2scdc_pkg::DIV_W;

    logic [N-1:0]                      valid_reg;
    logic [N-1:0]                      rem_reg [N];
    logic [N-1:0]                      q_reg   [N];
    logic [N-1:0]                      dvs_reg [N];
    logic [i2scdc_pkg::TAG_W-1:0]      tag_reg [N];

    logic [N-1:0] rem_in [N];
    logic [N-1:0] q_in   [N];
    logic [N-1:0] dvs_in [N];
    logic [N-1:0] rem_next [N];
    logic [N-1:0] q_next   [N];

    always_comb begin
        rem_in[0] = '0;
        q_in[0]   = dividend;
        dvs_in[0] = divisor;
        for (int k = 1; k < N; k++) begin
            rem_in[k] = rem_reg[k-1];
            q_in[k]   = q_reg[k-1];
            dvs_in[k] = dvs_reg[k-1];
        end
    end

    // q holds the unused dividend bits on top and quotient bits shifting in below
    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [N:0] t;
            logic [N:0] d;
            t = {rem_in[k], q_in[k][N-1]};
            d = {1'b0, dvs_in[k]};
            if (t >= d) begin
                rem_next[k] = N'(t - d);
                q_next[k]   = {q_in[k][N-2:0], 1'b1};
            end else begin
                rem_next[k] = t[N-1:0];
                q_next[k]   = {q_in[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= in_tag;
            for (int k = 0; k < N; k++) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                dvs_reg[k] <= dvs_in[k];
                if (k > 0) begin
                    tag_reg[k] <= tag_reg[k-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quotient  = q_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

[hdl/i2s_clock_divider_calc_top.sv]
// i2s_clock_divider_calc_top: i2s config word, prescaler and achieved rate per request
// depends on i2scdc_pkg and i2scdc_div_pipe
//
// usage:
//   s_ channel takes one setup request per beat, m_ channel returns one result
//   beat per request, in order. both use tvalid/tready; a beat moves when both
//   are high.
//   pipeline: 32 stages for source / rate, one rounding and clamp stage,
//   32 stages for the achieved rate division, one output register.
//   throughput: one request per cycle while the output is not stalled; the two
//   bit-per-stage dividers set the depth and each takes a new operand on every advance.
//   reset: synchronous active-low aresetn clears all valid bits; the pipe comes
//   out empty and s_tready is high.
//   stall: when m_tvalid is high and m_tready low the whole pipe freezes and
//   s_tready drops; nothing is lost or repeated.
module i2s_clock_divider_calc_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode_select, frame_format, frame_bits, sample_bits, source_clock_hz,
    // sample_rate_hz, clock_idle_high, master_clock_out, zero pad
    input  logic [i2scdc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // config_word, prescaler_word, achieved_rate_hz, rate_error, zero pad
    output logic [i2scdc_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic adv;

    logic [1:0]  in_mode;
    logic [3:0]  in_fmt;
    logic [6:0]  in_fbits;
    logic [5:0]  in_sbits;
    logic [31:0] in_src;
    logic [31:0] in_rate;
    logic        in_pol;
    logic        in_mck;

    i2scdc_pkg::tag1_t tag1_in, tag1_out;
    i2scdc_pkg::tag2_t tag2_in, tag2_out;

    logic        d1_valid, d2_valid;
    logic [31:0] quot1, quot2;

    logic        rnd_valid_reg;
    logic [31:0] rnd_dvd_reg, rnd_dvd_next;
    logic [8:0]  rnd_div_reg, rnd_div_next;
    logic [11:0] rnd_cfg_reg;
    logic        rnd_mck_reg, rnd_rz_reg;

    logic        m_valid_reg;
    logic [i2scdc_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    assign in_mode  = s_tdata[1:0];
    assign in_fmt   = s_tdata[5:2];
    assign in_fbits = s_tdata[12:6];
    assign in_sbits = s_tdata[18:13];
    assign in_src   = s_tdata[50:19];
    assign in_rate  = s_tdata[82:51];
    assign in_pol   = s_tdata[83];
    assign in_mck   = s_tdata[84];

    // channel and data length, shift count
    always_comb begin
        logic [3:0] base;
        tag1_in.chlen  = 1'b1;
        tag1_in.datlen = 2'd0;
        if (in_sbits <= 6'd16) begin
            tag1_in.chlen = (in_fbits > 7'd16);
        end else if (in_sbits > 6'd24) begin
            tag1_in.datlen = 2'd2;
        end else begin
            tag1_in.datlen = 2'd1;
        end
        base = in_mck ? i2scdc_pkg::SHIFT_MCK
                      : i2scdc_pkg::SHIFT_BASE + {3'd0, tag1_in.chlen};
        tag1_in.shift = base + {3'd0, (in_fmt < i2scdc_pkg::FMT_FIRST_PCM)};
        tag1_in.mode      = in_mode;
        tag1_in.fmt       = in_fmt;
        tag1_in.pol       = in_pol;
        tag1_in.mck       = in_mck;
        tag1_in.src       = in_src;
        tag1_in.rate_zero = (in_rate == 32'd0);
    end

    i2scdc_div_pipe u_div_rate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .dividend  (in_src),
        .divisor   (in_rate),
        .in_tag    (tag1_in),
        .out_valid (d1_valid),
        .quotient  (quot1),
        .out_tag   (tag1_out)
    );

    // round to nearest after the shift, 33-bit sum, then clamp
    always_comb begin
        logic [32:0] sum;
        logic [32:0] sh;
        sum = {1'b0, quot1} + (33'd1 << (tag1_out.shift - 4'd1));
        sh  = sum >> tag1_out.shift;
        if (sh < {24'd0, i2scdc_pkg::DIV_MIN}) begin
            rnd_div_next = i2scdc_pkg::DIV_MIN;
        end else if (sh > {24'd0, i2scdc_pkg::DIV_MAX}) begin
            rnd_div_next = i2scdc_pkg::DIV_MAX;
        end else begin
            rnd_div_next = sh[8:0];
        end
        rnd_dvd_next = tag1_out.src >> tag1_out.shift;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (adv) begin
            rnd_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rnd_dvd_reg <= rnd_dvd_next;
            rnd_div_reg <= rnd_div_next;
            rnd_cfg_reg <= {1'b1, 1'b0, tag1_out.mode, tag1_out.fmt, tag1_out.pol,
                            tag1_out.datlen, tag1_out.chlen};
            rnd_mck_reg <= tag1_out.mck;
            rnd_rz_reg  <= tag1_out.rate_zero;
        end
    end

    always_comb begin
        tag2_in.pad       = '0;
        tag2_in.cfg       = rnd_cfg_reg;
        tag2_in.mck       = rnd_mck_reg;
        tag2_in.rate_zero = rnd_rz_reg;
        tag2_in.div       = rnd_div_reg;
    end

    i2scdc_div_pipe u_div_achieved (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rnd_valid_reg),
        .dividend  (rnd_dvd_reg),
        .divisor   ({23'd0, rnd_div_reg}),
        .in_tag    (tag2_in),
        .out_valid (d2_valid),
        .quotient  (quot2),
        .out_tag   (tag2_out)
    );

    always_comb begin
        m_data_next = {1'b0, tag2_out.rate_zero, quot2,
                       tag2_out.mck, tag2_out.div[0], tag2_out.div[8:1],
                       tag2_out.cfg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // zero rate forces the widest divider
    a_zero_rate_max_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[54] |-> m_tdata[20:12] == 9'h1ff)
        else $error("zero rate did not clamp divider to max");

    // divider never below the minimum
    a_div_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:12] >= 8'd2)
        else $error("divider below minimum");

    // i2s mode bit always set, the bit below it always clear
    a_i2s_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11] && !m_tdata[10])
        else $error("config word fixed bits wrong");

    // frozen output while stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> m_tvalid && $stable(m_tdata))
        else $error("output moved during stall");
`endif

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for the i2s clock divider calculator
// depends on i2scdc_pkg and i2s_clock_divider_calc_top; predicts each result beat in place
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  fmt;
        logic [6:0]  fbits;
        logic [5:0]  sbits;
        logic [31:0] src;
        logic [31:0] rate;
        logic        pol;
        logic        mck;
    } setup_t;

    typedef struct packed {
        logic [11:0] cfg;
        logic [9:0]  presc;
        logic [31:0] achieved;
        logic        rate_err;
    } calc_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [i2scdc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [i2scdc_pkg::M_TDATA_W-1:0] m_tdata;

    calc_t expected_calcs[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned hold_off = 0;
    bit rx_idle_en = 1'b1;
    bit tx_idle_en = 1'b1;

    i2s_clock_divider_calc_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial forever #4 aclk = ~aclk;

    function automatic calc_t predict_calc(setup_t s);
        logic       chlen;
        logic [1:0] datlen;
        int unsigned shift;
        logic [31:0] quot;
        logic [32:0] total;
        logic [32:0] dv;
        logic [8:0]  d;
        calc_t r;
        chlen = 1'b1;
        datlen = 2'd0;
        if (s.sbits <= 16) chlen = (s.fbits > 16);
        else if (s.sbits > 24) datlen = 2'd2;
        else datlen = 2'd1;
        shift = (s.mck ? 7 : 4 + chlen) + ((s.fmt < i2scdc_pkg::FMT_FIRST_PCM) ? 1 : 0);
        quot = (s.rate != 0) ? s.src / s.rate : 32'hffff_ffff;
        total = {1'b0, quot} + (33'd1 << (shift - 1));
        dv = total >> shift;
        if (dv < i2scdc_pkg::DIV_MIN) d = i2scdc_pkg::DIV_MIN;
        else if (dv > i2scdc_pkg::DIV_MAX) d = i2scdc_pkg::DIV_MAX;
        else d = dv[8:0];
        r.cfg = {1'b1, 1'b0, s.mode, s.fmt, s.pol, datlen, chlen};
        r.presc = {s.mck, d[0], d[8:1]};
        r.achieved = (s.src >> shift) / d;
        r.rate_err = (s.rate == 0);
        return r;
    endfunction

    function automatic logic [i2scdc_pkg::S_TDATA_W-1:0] pack_setup(setup_t s);
        return {{(i2scdc_pkg::S_TDATA_W-85){1'b0}}, s.mck, s.pol, s.rate, s.src,
                s.sbits, s.fbits, s.fmt, s.mode};
    endfunction

    // valid stays high between beats sent back to back
    task automatic send_setup(setup_t s);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 19) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        expected_calcs.push_back(predict_calc(s));
        s_tdata <= pack_setup(s);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic setup_t random_setup();
        setup_t s;
        s.mode = 2'($urandom);
        s.fmt = 4'($urandom);
        s.fbits = 7'($urandom_range(0, 64));
        s.sbits = 6'($urandom_range(0, 32));
        s.pol = 1'($urandom);
        s.mck = 1'($urandom);
        case ($urandom_range(0, 5))
            0: s.src = $urandom;
            1: s.src = $urandom_range(0, 2000);
            default: s.src = $urandom_range(1000000, 200000000);
        endcase
        case ($urandom_range(0, 7))
            0: s.rate = $urandom;
            1: s.rate = 32'd0;
            2: s.rate = $urandom_range(1, 50);
            default: s.rate = $urandom_range(4000, 400000);
        endcase
        return s;
    endfunction

    // receiver: random ready, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_off != 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (rx_idle_en) begin
            m_tready <= ($urandom_range(0, 19) < 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        calc_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.cfg = m_tdata[11:0];
            got.presc = m_tdata[21:12];
            got.achieved = m_tdata[53:22];
            got.rate_err = m_tdata[54];
            if (expected_calcs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = expected_calcs.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch cfg %h/%h presc %h/%h rate %0d/%0d err %b/%b",
                                 want.cfg, got.cfg, want.presc, got.presc,
                                 want.achieved, got.achieved, want.rate_err, got.rate_err);
                end
            end
        end
    end

    initial begin
        wait (cycles > 2000000);
        $display("FAILURE");
        $finish;
    end

    task automatic test_directed();
        setup_t s;
        for (int i = 0; i < 24; i++) begin
            s = random_setup();
            s.mode = 2'(i % 4);
            s.fmt = 4'((i < 16) ? i : 15 * (i % 2));
            s.fbits = 7'((i % 3 == 0) ? 0 : ((i % 3 == 1) ? 16 : 64));
            s.sbits = 6'((i % 4 == 0) ? 0 : ((i % 4 == 1) ? 16 : ((i % 4 == 2) ? 24 : 32)));
            s.pol = i[0];
            s.mck = i[1];
            case (i % 6)
                0: begin s.src = 32'hffff_ffff; s.rate = 32'd0; end
                1: begin s.src = 32'hffff_ffff; s.rate = 32'd1; end
                2: begin s.src = 32'd0; s.rate = 32'hffff_ffff; end
                3: begin s.src = 32'hffff_ffff; s.rate = 32'hffff_ffff; end
                4: begin s.src = 32'd49152000; s.rate = 32'd48000; end
                default: begin s.src = 32'd0; s.rate = 32'd0; end
            endcase
            send_setup(s);
        end
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            // a run without idling now and then
            if (i % 200 == 100) begin tx_idle_en = 1'b0; rx_idle_en = 1'b0; end
            if (i % 200 == 140) begin tx_idle_en = 1'b1; rx_idle_en = 1'b1; end
            send_setup(random_setup());
        end
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_off = 300;
        for (int i = 0; i < 120; i++) send_setup(random_setup());
        tx_idle_en = 1'b1;
        // sender pauses until the pipe drains
        send_idle();
        wait (expected_calcs.size() == 0);
        for (int i = 0; i < 20; i++) send_setup(random_setup());
        send_idle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(700);
        test_backpressure();
        wait (expected_calcs.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_calcs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[files.f]
hdl/i2scdc_pkg.sv
hdl/i2scdc_div_pipe.sv
hdl/i2s_clock_divider_calc_top.sv
tb/testbench.sv
